/* sv/mevq_pkg.sv */
// ============================================================================
// mevq_pkg
// shared types, codes and helper functions of the midi event generator
// ============================================================================
package mevq_pkg;

   // message ring geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PEND_W      = 4;

   // field widths
   localparam int OP_W     = 4;
   localparam int VOICE_W  = 3;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 13;
   localparam int MS_W     = 16;
   localparam int GATE_W   = 11;
   localparam int CHAN_W   = 4;
   localparam int KIND_W   = 2;
   localparam int MTYPE_W  = 3;
   localparam int SEQ_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = 6;
   localparam int PLAN_LEN   = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DRUM_CHANNEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASS_CHANNEL = 1'd1;

   localparam logic [CHAN_W-1:0] DRUM_CHANNEL_RST = 4'd9;
   localparam logic [CHAN_W-1:0] BASS_CHANNEL_RST = 4'd0;
   localparam logic [NOTE_W-1:0] BASS_NOTE_RST    = 7'd36;

   // gate limits in ms
   localparam logic [GATE_W-1:0] GATE_MIN = 11'd30;
   localparam logic [GATE_W-1:0] GATE_MAX = 11'd2000;

   // midi constants
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [7:0] STATUS_CTRL     = 8'hB0;
   localparam logic [7:0] STATUS_START    = 8'hFA;
   localparam logic [7:0] STATUS_STOP    = 8'hFC;
   localparam logic [NOTE_W-1:0] CC_ALL_NOTES_OFF = 7'd123;

   typedef enum logic [OP_W-1:0] {
      OP_START      = 4'd0,
      OP_STOP       = 4'd1,
      OP_DRUM_TRIG  = 4'd2,
      OP_BASS_TRIG  = 4'd3,
      OP_VOICE_OFF  = 4'd4,
      OP_BASS_REL   = 4'd5,
      OP_ALL_OFF    = 4'd6,
      OP_TICK       = 4'd7,
      OP_POP        = 4'd8
   } op_type;

   localparam logic [VOICE_W-1:0] KICK_VOICE = 3'd0;
   localparam logic [VOICE_W-1:0] BASS_VOICE = 3'd4;
   localparam logic [VOICE_W-1:0] VOICE_NONE = 3'd5;

   typedef enum logic [KIND_W-1:0] {
      KIND_EMITTED = 2'd0,
      KIND_POPPED  = 2'd1,
      KIND_EMPTY   = 2'd2
   } kind_type;

   typedef enum logic [MTYPE_W-1:0] {
      MT_NOTE_ON  = 3'd0,
      MT_NOTE_OFF = 3'd1,
      MT_CTRL     = 3'd2,
      MT_START    = 3'd3,
      MT_STOP     = 3'd4
   } mtype_type;

   // which message a plan step produces
   typedef enum logic [2:0] {
      MSG_BASS_OFF,
      MSG_START,
      MSG_STOP,
      MSG_DRUM_ON,
      MSG_BASS_ON,
      MSG_DRUM_OFF,
      MSG_CC_BASS,
      MSG_CC_DRUM
   } msg_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_POP_RD,
      ST_POP_OUT
   } state_type;

   // one ring entry, 62 bits
   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [VOICE_W-1:0] src;
      logic [1:0]         len;
      logic [NOTE_W-1:0]  d2;
      logic [NOTE_W-1:0]  d1;
      logic [7:0]         status;
      logic [MTYPE_W-1:0] mtype;
   } entry_type;

   typedef struct packed {
      logic [PTR_W-1:0] occupancy;
      logic             empty;
      logic             full;
   } ring_status_type;

   function automatic logic [NOTE_W-1:0] drum_note(input logic [VOICE_W-1:0] voice);
      logic [NOTE_W-1:0] n;
      case (voice)
         3'd0:    n = 7'd36;
         3'd1:    n = 7'd38;
         3'd2:    n = 7'd42;
         3'd3:    n = 7'd46;
         default: n = 7'd0;
      endcase
      return n;
   endfunction

   // q12 strength to 1..127, half rounds up
   function automatic logic [NOTE_W-1:0] scale_velocity(input logic [VEL_W-1:0] v);
      logic [VEL_W-1:0] vs;
      logic [19:0]      prod;
      vs   = (v > 13'd4096) ? 13'd4096 : v;
      prod = 20'(vs) * 20'd126 + 20'd2048;
      return 7'(prod[19:12]) + 7'd1;
   endfunction

   function automatic logic [GATE_W-1:0] clamp_gate(input logic [MS_W-1:0] g);
      logic [GATE_W-1:0] r;
      if (g < 16'(GATE_MIN))
         r = GATE_MIN;
      else if (g > 16'(GATE_MAX))
         r = GATE_MAX;
      else
         r = g[GATE_W-1:0];
      return r;
   endfunction

endpackage

/* sv/mevq_ring.sv */
// ============================================================================
// mevq_ring
// message ring: one synchronous memory with pointers, drops oldest when full
// ============================================================================
module mevq_ring (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mevq_pkg::entry_type       push_entry,
   input  logic                      pop,
   input  logic                      rd_req,
   output mevq_pkg::entry_type       rd_entry,
   output mevq_pkg::ring_status_type status
);
   import mevq_pkg::*;

   entry_type        mem [QUEUE_DEPTH];
   entry_type        rd_entry_ff;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0]   diff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff)
         diff = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      else
         diff = {1'b0, wr_ptr_ff} + (PTR_W+1)'(QUEUE_DEPTH) - {1'b0, rd_ptr_ff};
      status.occupancy = diff[PTR_W-1:0];
      status.empty     = (rd_ptr_ff == wr_ptr_ff);
      status.full      = (next_ptr(wr_ptr_ff) == rd_ptr_ff);
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
         if (status.full)
            rd_ptr_in = next_ptr(rd_ptr_ff);
      end else if (pop && !status.empty) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (rd_req)
         rd_entry_ff <= mem[rd_ptr_ff];
   end

   assign rd_entry = rd_entry_ff;

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !status.full |=> status.occupancy == $past(status.occupancy) + 1'b1)
      else $error("ring occupancy did not grow on push");

   a_push_full_holds: assert property (@(posedge clock) disable iff (reset)
      push && status.full |=> status.full)
      else $error("ring left full state on push with drop");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push && !status.empty
      |=> status.occupancy == $past(status.occupancy) - 1'b1)
      else $error("ring occupancy did not shrink on pop");

endmodule

/* sv/midi_event_generator_with_queue_unit.sv */
// ============================================================================
// midi_event_generator_with_queue_unit
// sequencer events to midi messages, with a message ring for later readout
// ============================================================================
// Each request is taken, then the block produces its results at one per
// cycle while rsp_tready is high: start, stop and drum trigger give one
// result (none for a voice without a drum note), voice off one for a drum
// voice (for the bass voice zero or one, releasing a held bass note; none
// for the others), a bass trigger one or two (a held bass note is released
// first), all notes off two or three, bass release and tick zero or one.
// A pop reads the ring, a synchronous memory: the read is issued in the
// state after the request is taken and its registered data is then loaded
// into the result. Output waits while rsp_tready is low; the next request is
// taken once the last result has been loaded into the result register. Every
// generated message gets the next 32-bit sequence number, is delivered with
// kind 0 and is written into a ring of QUEUE_DEPTH slots, of which one stays
// free; when the ring is full the oldest entry is dropped. pending reports
// the ring occupancy after the result. Velocity is q12 and maps to 1..127,
// the bass gate is clamped to 30..2000 ms and counts down on tick requests,
// releasing the bass note when it runs out. The channel registers are written
// through the csr port, which is always ready; write them only while idle.
// ============================================================================
module midi_event_generator_with_queue_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // voice, note, velocity, gate_ms, dt_ms (low to high)
   input  logic [mevq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op
   input  logic [mevq_pkg::OP_W-1:0]           req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // msg_type, status_byte, data_one, data_two, msg_length, source_voice,
   // sequence_res, pending, zero fill (low to high)
   output logic [mevq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind
   output logic [mevq_pkg::KIND_W-1:0]         rsp_tuser,
   output logic                                rsp_tlast,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mevq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mevq_pkg::CHAN_W-1:0]         csr_data
);
   import mevq_pkg::*;

   // request fields
   logic [OP_W-1:0]    in_op;
   logic [VOICE_W-1:0] in_voice;
   logic [NOTE_W-1:0]  in_note;
   logic [VEL_W-1:0]   in_vel;
   logic [MS_W-1:0]    in_gate;
   logic [MS_W-1:0]    in_dt;
   logic               accept;

   // control
   state_type          state_ff, state_in;
   msg_code_type       plan_ff [PLAN_LEN];
   msg_code_type       plan_in [PLAN_LEN];
   logic [1:0]         plan_cnt_ff, plan_cnt_in;
   logic [1:0]         step_ff, step_in;

   // latched request data
   logic [VOICE_W-1:0] voice_ff;
   logic [NOTE_W-1:0]  note_ff;
   logic [NOTE_W-1:0]  vel_ff;
   logic [NOTE_W-1:0]  prev_note_ff;

   // channels
   logic [CHAN_W-1:0]  drum_ch_ff;
   logic [CHAN_W-1:0]  bass_ch_ff;

   // bass voice and sequence state
   logic               bass_active_ff, bass_active_in;
   logic [NOTE_W-1:0]  bass_note_ff, bass_note_in;
   logic [GATE_W-1:0]  gate_left_ff, gate_left_in;
   logic [SEQ_W-1:0]   seq_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff;
   entry_type          rsp_entry_ff;
   logic [PEND_W-1:0]  rsp_pending_ff;
   logic               rsp_last_ff;

   // ring interface
   logic               push;
   logic               pop;
   logic               rd_req;
   entry_type          rd_entry;
   ring_status_type    ring_st;

   // result load
   logic               load_out;
   logic               out_free;
   kind_type           out_kind;
   entry_type          out_entry;
   entry_type          cur_entry;
   logic [PEND_W-1:0]  out_pending;
   logic               out_last;

   // plan building
   msg_code_type       m0, m1;
   logic [1:0]         mcnt;
   logic               rel;
   logic               tick_due;

   assign in_op    = req_tuser;
   assign in_voice = req_tdata[2:0];
   assign in_note  = req_tdata[9:3];
   assign in_vel   = req_tdata[22:10];
   assign in_gate  = req_tdata[38:23];
   assign in_dt    = req_tdata[54:39];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // channel registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drum_ch_ff <= DRUM_CHANNEL_RST;
         bass_ch_ff <= BASS_CHANNEL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DRUM_CHANNEL: drum_ch_ff <= csr_data;
            CSR_BASS_CHANNEL: bass_ch_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // message plan for the accepted request: optional bass release, then the op's own
   assign tick_due = (in_dt != '0) && (in_dt >= MS_W'(gate_left_ff));

   always_comb begin
      m0   = MSG_START;
      m1   = MSG_START;
      mcnt = 2'd0;
      case (in_op)
         OP_START: begin
            m0   = MSG_START;
            mcnt = 2'd1;
         end
         OP_STOP: begin
            m0   = MSG_STOP;
            mcnt = 2'd1;
         end
         OP_DRUM_TRIG: begin
            m0 = MSG_DRUM_ON;
            if (in_voice < BASS_VOICE)
               mcnt = 2'd1;
         end
         OP_BASS_TRIG: begin
            m0   = MSG_BASS_ON;
            mcnt = 2'd1;
         end
         OP_VOICE_OFF: begin
            m0 = MSG_DRUM_OFF;
            if (in_voice < BASS_VOICE)
               mcnt = 2'd1;
         end
         OP_ALL_OFF: begin
            m0   = MSG_CC_BASS;
            m1   = MSG_CC_DRUM;
            mcnt = 2'd2;
         end
         default: ;
      endcase

      rel = 1'b0;
      if (bass_active_ff) begin
         case (in_op) inside
            OP_BASS_TRIG, OP_BASS_REL, OP_ALL_OFF: rel = 1'b1;
            OP_VOICE_OFF: rel = (in_voice == BASS_VOICE);
            OP_TICK:      rel = tick_due;
            default:      rel = 1'b0;
         endcase
      end

      if (rel) begin
         plan_in[0]  = MSG_BASS_OFF;
         plan_in[1]  = m0;
         plan_in[2]  = m1;
         plan_cnt_in = mcnt + 2'd1;
      end else begin
         plan_in[0]  = m0;
         plan_in[1]  = m1;
         plan_in[2]  = m1;
         plan_cnt_in = mcnt;
      end
   end

   // bass voice update happens at accept; messages use the latched copies
   always_comb begin
      bass_active_in = bass_active_ff;
      bass_note_in   = bass_note_ff;
      gate_left_in   = gate_left_ff;
      if (accept) begin
         if (in_op == OP_BASS_TRIG) begin
            bass_active_in = 1'b1;
            bass_note_in   = in_note;
            gate_left_in   = clamp_gate(in_gate);
         end else if (rel) begin
            bass_active_in = 1'b0;
            gate_left_in   = '0;
         end else if (in_op == OP_TICK && bass_active_ff && in_dt != '0) begin
            gate_left_in = gate_left_ff - in_dt[GATE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bass_active_ff <= 1'b0;
         bass_note_ff   <= BASS_NOTE_RST;
         gate_left_ff   <= '0;
      end else begin
         bass_active_ff <= bass_active_in;
         bass_note_ff   <= bass_note_in;
         gate_left_ff   <= gate_left_in;
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         plan_ff      <= plan_in;
         plan_cnt_ff  <= plan_cnt_in;
         voice_ff     <= in_voice;
         note_ff      <= in_note;
         vel_ff       <= scale_velocity(in_vel);
         prev_note_ff <= bass_note_ff;
      end
   end

   // message for the current plan step
   always_comb begin
      cur_entry     = '0;
      cur_entry.seq = seq_ff;
      cur_entry.len = 2'd3;
      case (plan_ff[step_ff])
         MSG_BASS_OFF: begin
            cur_entry.mtype  = MT_NOTE_OFF;
            cur_entry.status = STATUS_NOTE_OFF | 8'(bass_ch_ff);
            cur_entry.d1     = prev_note_ff;
            cur_entry.src    = BASS_VOICE;
         end
         MSG_START: begin
            cur_entry.mtype  = MT_START;
            cur_entry.status = STATUS_START;
            cur_entry.len    = 2'd1;
            cur_entry.src    = VOICE_NONE;
         end
         MSG_STOP: begin
            cur_entry.mtype  = MT_STOP;
            cur_entry.status = STATUS_STOP;
            cur_entry.len    = 2'd1;
            cur_entry.src    = VOICE_NONE;
         end
         MSG_DRUM_ON: begin
            cur_entry.mtype  = MT_NOTE_ON;
            cur_entry.status = STATUS_NOTE_ON | 8'(drum_ch_ff);
            cur_entry.d1     = drum_note(voice_ff);
            cur_entry.d2     = vel_ff;
            cur_entry.src    = voice_ff;
         end
         MSG_BASS_ON: begin
            cur_entry.mtype  = MT_NOTE_ON;
            cur_entry.status = STATUS_NOTE_ON | 8'(bass_ch_ff);
            cur_entry.d1     = note_ff;
            cur_entry.d2     = vel_ff;
            cur_entry.src    = BASS_VOICE;
         end
         MSG_DRUM_OFF: begin
            cur_entry.mtype  = MT_NOTE_OFF;
            cur_entry.status = STATUS_NOTE_OFF | 8'(drum_ch_ff);
            cur_entry.d1     = drum_note(voice_ff);
            cur_entry.src    = voice_ff;
         end
         MSG_CC_BASS: begin
            cur_entry.mtype  = MT_CTRL;
            cur_entry.status = STATUS_CTRL | 8'(bass_ch_ff);
            cur_entry.d1     = CC_ALL_NOTES_OFF;
            cur_entry.src    = BASS_VOICE;
         end
         MSG_CC_DRUM: begin
            cur_entry.mtype  = MT_CTRL;
            cur_entry.status = STATUS_CTRL | 8'(drum_ch_ff);
            cur_entry.d1     = CC_ALL_NOTES_OFF;
            cur_entry.src    = VOICE_NONE;
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      push        = 1'b0;
      pop         = 1'b0;
      rd_req      = 1'b0;
      load_out    = 1'b0;
      out_kind    = KIND_EMITTED;
      out_entry   = cur_entry;
      out_pending = PEND_W'(ring_st.occupancy);
      out_last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in = '0;
               if (in_op == OP_POP)
                  state_in = ST_POP_RD;
               else if (plan_cnt_in != '0)
                  state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               push     = 1'b1;
               load_out = 1'b1;
               out_last = (step_ff == plan_cnt_ff - 2'd1);
               // a full ring drops its oldest entry, occupancy stays
               if (!ring_st.full)
                  out_pending = PEND_W'(ring_st.occupancy + 1'b1);
               if (out_last)
                  state_in = ST_IDLE;
               else
                  step_in = step_ff + 2'd1;
            end
         end
         ST_POP_RD: begin
            rd_req   = 1'b1;
            state_in = ST_POP_OUT;
         end
         ST_POP_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               out_last = 1'b1;
               state_in = ST_IDLE;
               if (!ring_st.empty) begin
                  pop         = 1'b1;
                  out_kind    = KIND_POPPED;
                  out_entry   = rd_entry;
                  out_pending = PEND_W'(ring_st.occupancy - 1'b1);
               end else begin
                  out_kind      = KIND_EMPTY;
                  out_entry     = '0;
                  out_entry.src = VOICE_NONE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequence counter advances with every generated message
   always_ff @(posedge clock) begin
      if (reset)
         seq_ff <= '0;
      else if (push)
         seq_ff <= seq_ff + 1'b1;
   end

   mevq_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (cur_entry),
      .pop        (pop),
      .rd_req     (rd_req),
      .rd_entry   (rd_entry),
      .status     (ring_st)
   );

   // result register, refilled in the cycle it is taken
   always_comb begin
      if (load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_kind_ff    <= out_kind;
         rsp_entry_ff   <= out_entry;
         rsp_pending_ff <= out_pending;
         rsp_last_ff    <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_pending_ff, rsp_entry_ff.seq, rsp_entry_ff.src,
                        rsp_entry_ff.len, rsp_entry_ff.d2, rsp_entry_ff.d1,
                        rsp_entry_ff.status, rsp_entry_ff.mtype};

   a_gate_held: assert property (@(posedge clock) disable iff (reset)
      bass_active_ff |-> gate_left_ff >= 11'd1 && gate_left_ff <= GATE_MAX)
      else $error("held bass note with gate out of range");

   a_gate_idle: assert property (@(posedge clock) disable iff (reset)
      !bass_active_ff |-> gate_left_ff == '0)
      else $error("released bass note left a gate count");

   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      push |=> seq_ff == $past(seq_ff) + 1'b1)
      else $error("sequence number did not advance on message");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten before it was taken");

endmodule
